[hw/rtl/psfd_pkg.sv]
`default_nettype none

package psfd_pkg;

    localparam int unsigned FRAME_BYTES = 6;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // frame byte positions
    localparam logic [2:0] POS_P_HI  = 3'd0;
    localparam logic [2:0] POS_P_LO  = 3'd1;
    localparam logic [2:0] POS_P_CRC = 3'd2;
    localparam logic [2:0] POS_T_HI  = 3'd3;
    localparam logic [2:0] POS_T_LO  = 3'd4;
    localparam logic [2:0] POS_T_CRC = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_PRESSURE_OFFSET = 2'd0;
    localparam logic [1:0] REG_SENSOR_READY    = 2'd1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_BUS_ERROR = 2'd2,
        ST_CRC_BAD   = 2'd3
    } status_t;

    // round(64*a/15) = floor((64*a + 7) * P_RECIP >> RECIP_SHIFT), exact for a <= 2^15
    localparam int unsigned RECIP_SHIFT = 26;
    localparam logic [22:0] P_RECIP     = 23'd4473925;
    localparam logic [21:0] P_BIAS      = 22'd7;
    // round(32*a/25), same scheme
    localparam logic [21:0] T_RECIP     = 22'd2684355;
    localparam logic [20:0] T_BIAS      = 21'd12;

    localparam logic signed [18:0] CORR_MAX = 19'sh3FFFF;
    localparam logic signed [18:0] CORR_MIN = -19'sh40000;

    // one byte through the CRC-8, MSB first
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [15:0]      pressure_word;
        logic [15:0]      temperature_word;
    } frame_word_t;

endpackage

`default_nettype wire

[hw/rtl/psfd_if.sv]
`default_nettype none

interface psfd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       read_failed;

    modport source (output valid, output frame_byte, output frame_start,
                    output read_failed, input ready);
    modport sink   (input valid, input frame_byte, input frame_start,
                    input read_failed, output ready);
endinterface

interface psfd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [18:0] differential_pressure;
    logic signed [18:0] corrected_pressure;
    logic signed [16:0] temperature;

    modport source (output valid, output status, output differential_pressure,
                    output corrected_pressure, output temperature, input ready);
    modport sink   (input valid, input status, input differential_pressure,
                    input corrected_pressure, input temperature, output ready);
endinterface

interface psfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [18:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pressure_sensor_frame_decoder.sv]
// Sensor sample frame decoder.
// frame channel: one received byte per beat, in the order pressure high, pressure
//   low, pressure CRC, temperature high, temperature low, temperature CRC.
//   frame_start restarts the frame at this byte; read_failed aborts the frame and
//   yields an error result at once, the byte itself being dropped.
// result channel: one beat per completed or aborted frame: status and the three
//   Q.8 values (zero unless status is ok).
// cfg channel: register 0 pressure_offset, register 1 sensor_ready; always ready,
//   to be written only while no frame result is pending; the block does not enforce this.
// Throughput: one byte beat per cycle while frame.ready is high. The CRC step runs at the input; the
// constant scalings run between the frame word register and the result register.
// The beat that completes a frame loads the frame word register, then the result register.
// Stall: while the result is not taken, one more finished frame is held in the
//   word register; frame.ready drops only when both are full.
// Reset: position and CRC restart, offset 0, sensor not ready, no result pending.

`default_nettype none

module pressure_sensor_frame_decoder
    import psfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    psfd_frame_if.sink      frame,
    psfd_result_if.source   result,
    psfd_cfg_if.sink        cfg
);

    logic signed [18:0] offset_reg;
    logic               sensor_ready_reg;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] pw_reg, pw_next;
    logic [15:0] tw_reg, tw_next;
    logic        ffail_reg, ffail_next;

    logic [2:0]  pos;
    logic [7:0]  crc_cur;
    logic        ffail_cur;
    logic        bad;
    logic        emit;
    status_t     emit_status;

    frame_word_t word_reg, word_next;
    logic        word_adv;
    logic        accept;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic signed [18:0] out_dp_reg;
    logic signed [18:0] out_cp_reg;
    logic signed [16:0] out_t_reg;

    logic [1:0]         sc_status;
    logic signed [18:0] sc_dp;
    logic signed [18:0] sc_cp;
    logic signed [16:0] sc_t;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg       <= '0;
            sensor_ready_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PRESSURE_OFFSET: offset_reg       <= $signed(cfg.data);
                REG_SENSOR_READY:    sensor_ready_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // frame assembly and CRC checks
    assign word_adv    = word_reg.valid && (!out_valid_reg || result.ready);
    assign frame.ready = !word_reg.valid || word_adv;
    assign accept      = frame.valid && frame.ready;

    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        pw_next     = pw_reg;
        tw_next     = tw_reg;
        ffail_next  = ffail_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        bad         = 1'b0;

        pos       = frame.frame_start ? POS_P_HI : pos_reg;
        crc_cur   = frame.frame_start ? CRC_INIT : crc_reg;
        ffail_cur = frame.frame_start ? 1'b0 : ffail_reg;
        if (32'(pos) >= FRAME_BYTES)
        begin
            pos = POS_P_HI;
        end

        if (frame.read_failed)
        begin
            pos_next    = POS_P_HI;
            crc_next    = CRC_INIT;
            ffail_next  = 1'b0;
            emit        = 1'b1;
            emit_status = sensor_ready_reg ? ST_BUS_ERROR : ST_NOT_READY;
        end
        else
        begin
            ffail_next = ffail_cur;
            unique case (pos)
                POS_P_HI:
                begin
                    crc_next   = crc_step(CRC_INIT, frame.frame_byte);
                    ffail_next = 1'b0;
                    pw_next    = {frame.frame_byte, pw_reg[7:0]};
                    pos_next   = POS_P_LO;
                end
                POS_P_LO:
                begin
                    crc_next = crc_step(crc_cur, frame.frame_byte);
                    pw_next  = {pw_reg[15:8], frame.frame_byte};
                    pos_next = POS_P_CRC;
                end
                POS_P_CRC:
                begin
                    ffail_next = (crc_cur != frame.frame_byte);
                    crc_next   = CRC_INIT;
                    pos_next   = POS_T_HI;
                end
                POS_T_HI:
                begin
                    crc_next = crc_step(CRC_INIT, frame.frame_byte);
                    tw_next  = {frame.frame_byte, tw_reg[7:0]};
                    pos_next = POS_T_LO;
                end
                POS_T_LO:
                begin
                    crc_next = crc_step(crc_cur, frame.frame_byte);
                    tw_next  = {tw_reg[15:8], frame.frame_byte};
                    pos_next = POS_T_CRC;
                end
                default:
                begin
                    bad        = ffail_cur || (crc_cur != frame.frame_byte);
                    pos_next   = POS_P_HI;
                    crc_next   = CRC_INIT;
                    ffail_next = 1'b0;
                    emit       = 1'b1;
                    if (!sensor_ready_reg)
                    begin
                        emit_status = ST_NOT_READY;
                    end
                    else if (bad)
                    begin
                        emit_status = ST_CRC_BAD;
                    end
                    else
                    begin
                        emit_status = ST_OK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_P_HI;
            crc_reg   <= CRC_INIT;
            pw_reg    <= '0;
            tw_reg    <= '0;
            ffail_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            pw_reg    <= pw_next;
            tw_reg    <= tw_next;
            ffail_reg <= ffail_next;
        end
    end

    // frame word register
    always_comb
    begin
        word_next = word_reg;
        if (accept && emit)
        begin
            word_next.valid            = 1'b1;
            word_next.status           = emit_status;
            word_next.pressure_word    = pw_reg;
            word_next.temperature_word = tw_reg;
        end
        else if (word_adv)
        begin
            word_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    psfd_scale u_scale (
        .word                  (word_reg),
        .pressure_offset       (offset_reg),
        .status                (sc_status),
        .differential_pressure (sc_dp),
        .corrected_pressure    (sc_cp),
        .temperature           (sc_t)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (word_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_adv)
        begin
            out_status_reg <= sc_status;
            out_dp_reg     <= sc_dp;
            out_cp_reg     <= sc_cp;
            out_t_reg      <= sc_t;
        end
    end

    assign result.valid                 = out_valid_reg;
    assign result.status                = out_status_reg;
    assign result.differential_pressure = out_dp_reg;
    assign result.corrected_pressure    = out_cp_reg;
    assign result.temperature           = out_t_reg;

    // error results carry zero values
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_OK) |->
            (result.differential_pressure == '0 && result.corrected_pressure == '0 &&
             result.temperature == '0))
        else $error("error result with nonzero values");

    // input stalls only when both result stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !frame.ready |-> (word_reg.valid && out_valid_reg && !result.ready))
        else $error("input stalled with free result stage");

    // an aborted read always produces a result beat
    a_fail_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready && frame.read_failed) |=> word_reg.valid)
        else $error("read failure lost");

endmodule

`default_nettype wire

[hw/rtl/psfd_scale.sv]
`default_nettype none

module psfd_scale
    import psfd_pkg::*;
(
    input  wire frame_word_t        word,
    input  wire logic signed [18:0] pressure_offset,
    output logic [1:0]              status,
    output logic signed [18:0]      differential_pressure,
    output logic signed [18:0]      corrected_pressure,
    output logic signed [16:0]      temperature
);

    logic        p_neg;
    logic        t_neg;
    logic [15:0] p_mag;
    logic [15:0] t_mag;
    logic [21:0] p_num;
    logic [20:0] t_num;
    logic [44:0] p_prod;
    logic [42:0] t_prod;
    logic [18:0] p_q;
    logic [16:0] t_q;
    logic signed [18:0] dp;
    logic signed [16:0] tc;
    logic signed [19:0] cp_wide;
    logic signed [18:0] cp;
    logic               ok;

    always_comb
    begin
        p_neg = word.pressure_word[15];
        t_neg = word.temperature_word[15];
        // 16-bit negate of -32768 gives 0x8000, the right magnitude
        p_mag = p_neg ? (16'd0 - word.pressure_word) : word.pressure_word;
        t_mag = t_neg ? (16'd0 - word.temperature_word) : word.temperature_word;

        p_num  = {p_mag, 6'b0} + P_BIAS;
        t_num  = {t_mag, 5'b0} + T_BIAS;
        p_prod = 45'(p_num) * 45'(P_RECIP);
        t_prod = 43'(t_num) * 43'(T_RECIP);
        p_q    = p_prod[44:RECIP_SHIFT];
        t_q    = t_prod[42:RECIP_SHIFT];

        dp = p_neg ? -$signed(p_q) : $signed(p_q);
        tc = t_neg ? -$signed(t_q) : $signed(t_q);

        cp_wide = 20'(dp) - 20'(pressure_offset);
        if (cp_wide > 20'(CORR_MAX))
        begin
            cp = CORR_MAX;
        end
        else if (cp_wide < 20'(CORR_MIN))
        begin
            cp = CORR_MIN;
        end
        else
        begin
            cp = cp_wide[18:0];
        end

        ok                    = (word.status == ST_OK);
        status                = word.status;
        differential_pressure = ok ? dp : '0;
        corrected_pressure    = ok ? cp : '0;
        temperature           = ok ? tc : '0;
    end

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psfd_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int BEATS_PER_PHASE = 360;
    localparam int OFFSET_EXTREME  = 139810;

    typedef struct {
        status_t            status;
        logic signed [18:0] dp;
        logic signed [18:0] cp;
        logic signed [16:0] temp;
    } sample_t;

    logic clk;
    logic rst_n;

    psfd_frame_if  frame_bus();
    psfd_result_if result_bus();
    psfd_cfg_if    cfg_bus();

    pressure_sensor_frame_decoder i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // frame decoder model state
    logic [2:0]         frame_pos;
    logic [7:0]         crc_acc;
    logic [15:0]        p_word;
    logic [15:0]        t_word;
    logic               p_crc_bad;
    logic signed [18:0] offset_q8;
    logic               sensor_on;

    sample_t expected_samples[$];
    int      errors          = 0;
    int      beats_sent      = 0;
    int      send_idle_pct   = 0;
    int      recv_stall_pct  = 0;
    int      hold_off_cycles = 0;
    int      cycle_count     = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // half away from zero, den > 0
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
        begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    task automatic restart_frame_model();
        frame_pos = POS_P_HI;
        crc_acc   = CRC_INIT;
        p_crc_bad = 1'b0;
    endtask

    task automatic decode_beat(input logic [7:0] b, input logic start, input logic failed);
        sample_t    s;
        logic [2:0] p;
        logic       bad;
        longint     dp;
        longint     cp;
        longint     tv;
        s.status = ST_OK;
        s.dp     = '0;
        s.cp     = '0;
        s.temp   = '0;
        if (failed)
        begin
            restart_frame_model();
            s.status = sensor_on ? ST_BUS_ERROR : ST_NOT_READY;
            expected_samples.push_back(s);
        end
        else
        begin
            if (start)
            begin
                restart_frame_model();
            end
            p = frame_pos;
            if (32'(p) >= FRAME_BYTES)
            begin
                p = POS_P_HI;
            end
            case (p)
                POS_P_HI:
                begin
                    crc_acc      = crc8_byte(CRC_INIT, b);
                    p_crc_bad    = 1'b0;
                    p_word[15:8] = b;
                    frame_pos    = POS_P_LO;
                end
                POS_T_HI:
                begin
                    crc_acc      = crc8_byte(CRC_INIT, b);
                    t_word[15:8] = b;
                    frame_pos    = POS_T_LO;
                end
                POS_P_LO:
                begin
                    crc_acc     = crc8_byte(crc_acc, b);
                    p_word[7:0] = b;
                    frame_pos   = POS_P_CRC;
                end
                POS_T_LO:
                begin
                    crc_acc     = crc8_byte(crc_acc, b);
                    t_word[7:0] = b;
                    frame_pos   = POS_T_CRC;
                end
                POS_P_CRC:
                begin
                    p_crc_bad = (crc_acc != b);
                    crc_acc   = CRC_INIT;
                    frame_pos = POS_T_HI;
                end
                default:
                begin
                    bad = p_crc_bad || (crc_acc != b);
                    restart_frame_model();
                    if (!sensor_on)
                    begin
                        s.status = ST_NOT_READY;
                    end
                    else if (bad)
                    begin
                        s.status = ST_CRC_BAD;
                    end
                    else
                    begin
                        dp = round_div(longint'($signed(p_word)) * 64, 15);
                        tv = round_div(longint'($signed(t_word)) * 32, 25);
                        cp = dp - longint'(offset_q8);
                        if (cp > longint'(CORR_MAX))
                        begin
                            cp = longint'(CORR_MAX);
                        end
                        if (cp < longint'(CORR_MIN))
                        begin
                            cp = longint'(CORR_MIN);
                        end
                        s.dp   = dp[18:0];
                        s.cp   = cp[18:0];
                        s.temp = tv[16:0];
                    end
                    expected_samples.push_back(s);
                end
            endcase
        end
    endtask

    // result check, then model update for the beats of this edge
    always @(posedge clk)
    begin
        sample_t exp_s;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result beat with none expected, got status %0d",
                             $time, result_bus.status);
                end
                else
                begin
                    exp_s = expected_samples.pop_front();
                    if (result_bus.status !== exp_s.status ||
                        result_bus.differential_pressure !== exp_s.dp ||
                        result_bus.corrected_pressure !== exp_s.cp ||
                        result_bus.temperature !== exp_s.temp)
                    begin
                        errors++;
                        $display("%0t ns: mismatch expected st %0d dp %0d cp %0d t %0d",
                                 $time, exp_s.status, exp_s.dp, exp_s.cp, exp_s.temp);
                        $display("%0t ns:          actual   st %0d dp %0d cp %0d t %0d",
                                 $time, result_bus.status, result_bus.differential_pressure,
                                 result_bus.corrected_pressure, result_bus.temperature);
                    end
                end
            end
            if (frame_bus.valid && frame_bus.ready)
            begin
                decode_beat(frame_bus.frame_byte, frame_bus.frame_start,
                            frame_bus.read_failed);
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    REG_PRESSURE_OFFSET: offset_q8 = cfg_bus.data;
                    REG_SENSOR_READY:    sensor_on = cfg_bus.data[0];
                    default:             ;
                endcase
            end
        end
    end

    // result side: long hold-off first, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_off_cycles--;
        end
        else
        begin
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // returns at the edge that accepts the beat; valid stays high until the next call
    task automatic send_beat(input logic [7:0] b, input logic start, input logic failed);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_bus.valid <= 1'b0;
            @(negedge clk);
        end
        frame_bus.valid       <= 1'b1;
        frame_bus.frame_byte  <= b;
        frame_bus.frame_start <= start;
        frame_bus.read_failed <= failed;
        do
        begin
            @(posedge clk);
        end
        while (!frame_bus.ready);
        beats_sent++;
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [18:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_offset(input int off);
        logic [31:0] v;
        v = off;
        write_cfg(REG_PRESSURE_OFFSET, v[18:0]);
    endtask

    task automatic write_ready(input logic on);
        logic [18:0] v;
        v = 19'($urandom);
        v[0] = on;
        write_cfg(REG_SENSOR_READY, v);
    endtask

    // drop valid, drain every expected sample, let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        frame_bus.valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input logic [15:0] pw, input logic [15:0] tw, input logic start,
                              input logic bad_p, input logic bad_t);
        logic [7:0] pc;
        logic [7:0] tc;
        pc = crc8_byte(crc8_byte(CRC_INIT, pw[15:8]), pw[7:0]);
        tc = crc8_byte(crc8_byte(CRC_INIT, tw[15:8]), tw[7:0]);
        if (bad_p)
        begin
            pc ^= 8'($urandom_range(1, 255));
        end
        if (bad_t)
        begin
            tc ^= 8'($urandom_range(1, 255));
        end
        send_beat(pw[15:8], start, 1'b0);
        send_beat(pw[7:0], 1'b0, 1'b0);
        send_beat(pc, 1'b0, 1'b0);
        send_beat(tw[15:8], 1'b0, 1'b0);
        send_beat(tw[7:0], 1'b0, 1'b0);
        send_beat(tc, 1'b0, 1'b0);
    endtask

    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0:       w = 16'h0000;
                1:       w = 16'h7FFF;
                2:       w = 16'h8000;
                default: w = 16'hFFFF;
            endcase
        end
        return w;
    endfunction

    // mostly whole frames, some cut short, error beats and loose bytes
    task automatic random_burst();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            send_frame(pick_word(), pick_word(), 1'($urandom), $urandom_range(9) == 0,
                       $urandom_range(9) == 0);
        end
        else if (pick < 85)
        begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
            begin
                send_beat(8'($urandom), i == 0, 1'b0);
            end
            send_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0);
        end
        else if (pick < 93)
        begin
            send_beat(8'($urandom), 1'($urandom), 1'b1);
        end
        else
        begin
            send_beat(8'($urandom), 1'($urandom), 1'b0);
        end
    endtask

    task automatic test_not_ready_after_reset();
        send_beat(8'h00, 1'b0, 1'b1);
        send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_value_extremes();
        write_ready(1'b1);
        write_offset(-OFFSET_EXTREME);
        // corrected value clips high
        send_frame(16'h7FFF, 16'h8000, 1'b1, 1'b0, 1'b0);
        wait_idle();
        write_offset(OFFSET_EXTREME);
        // corrected value clips low
        send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_restart_and_errors();
        // partial frame dropped by a new start, a bad temperature check, a read failure, then a bad pressure check
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_frame(16'h1234, 16'hFEDC, 1'b0, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_off_cycles = 80;
        for (int i = 0; i < 6; i++)
        begin
            send_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b0);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    set_idling(0, 0);
                    write_offset(int'($urandom_range(2 * OFFSET_EXTREME)) - OFFSET_EXTREME);
                end
                1:
                begin
                    set_idling(53, 0);
                    write_offset(OFFSET_EXTREME);
                end
                2:
                begin
                    set_idling(0, 53);
                    write_offset(-OFFSET_EXTREME);
                end
                default:
                begin
                    set_idling(9, 9);
                    write_offset(0);
                end
            endcase
            write_ready(1'b1);
            target = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < target)
            begin
                random_burst();
            end
        end
        wait_idle();
        write_ready(1'b0);
        target = beats_sent + 60;
        while (beats_sent < target)
        begin
            random_burst();
        end
        wait_idle();
    endtask

    initial
    begin
        frame_bus.valid       = 1'b0;
        frame_bus.frame_byte  = '0;
        frame_bus.frame_start = 1'b0;
        frame_bus.read_failed = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = '0;
        cfg_bus.data          = '0;
        result_bus.ready      = 1'b0;
        offset_q8             = '0;
        sensor_on             = 1'b0;
        p_word                = '0;
        t_word                = '0;
        restart_frame_model();
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_not_ready_after_reset();
        test_value_extremes();
        test_restart_and_errors();
        test_backpressure();
        test_random_traffic();

        if (expected_samples.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d expected samples never arrived", $time,
                     expected_samples.size());
        end
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

[pressure_sensor_frame_decoder.f]
hw/rtl/psfd_pkg.sv
hw/rtl/psfd_if.sv
hw/rtl/psfd_scale.sv
hw/rtl/pressure_sensor_frame_decoder.sv
test/testbench.sv
